/* src/fuaeq_pkg.sv */
// Shared types and constants for the float ULP approximate-equality unit.
// No dependencies; imported by every module of the block.
package fuaeq_pkg;

  // Input word: precision select and two IEEE-754 bit patterns.
  typedef struct packed {
    logic        command;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
  } fuaeq_in_t;

  // Result word.
  typedef struct packed {
    logic        equal;
    logic [62:0] ulp_distance;
  } fuaeq_out_t;

  localparam logic CMD_SINGLE = 1'b0;
  localparam logic CMD_DOUBLE = 1'b1;

  localparam logic REG_ULP_SINGLE = 1'b0;
  localparam logic REG_ULP_DOUBLE = 1'b1;

  localparam int SGL_LIM_W = 31;
  localparam int DBL_LIM_W = 63;
  localparam logic [SGL_LIM_W-1:0] ULP_LIMIT_SINGLE_RST = 31'd8;
  localparam logic [DBL_LIM_W-1:0] ULP_LIMIT_DOUBLE_RST = 63'd16;

  localparam logic [62:0] DIST_MAX_SGL = 63'h0000_0000_7FFF_FFFF;
  localparam logic [62:0] DIST_MAX_DBL = 63'h7FFF_FFFF_FFFF_FFFF;

  // Mantissa with hidden bit, and fixed-point grid widths.
  localparam int MANT_W = 53;
  localparam int FX_W   = 107;  // grid of 2^-107 (double) / 2^-51 (single), below 1.0
  localparam int K_W    = FX_W + 1;

  // Grid offsets: shift = biased exponent - offset.
  localparam logic [12:0] GRID_OFS_SGL = 13'd99;
  localparam logic [12:0] GRID_OFS_DBL = 13'd968;

  // Magnitudes below 2^-28 / 2^-55 lie within tolerance of each other.
  localparam logic [10:0] TINY_EXP_SGL = 11'd99;
  localparam logic [10:0] TINY_EXP_DBL = 11'd968;
  // Biased exponent of 1.0.
  localparam logic [10:0] ONE_EXP_SGL  = 11'd127;
  localparam logic [10:0] ONE_EXP_DBL  = 11'd1023;

  // Midpoint between the rounded tolerance and its predecessor, in grid units.
  localparam logic [K_W-1:0] TOL_MID_SGL = 108'h15798ED;
  localparam logic [K_W-1:0] TOL_MID_DBL = 108'h39A5652FB11377;

endpackage

/* src/float_ulp_approx_equal_unit.sv */
// Float ULP approximate-equality unit: tolerance test and ULP-distance test.
// Depends on fuaeq_pkg and fuaeq_to_fixed.
// An accepted start passes the unpack, order, difference and compare stages, each registered, to the out_valid strobe.
// Throughput: one word per cycle; busy stays low, the pipeline never stalls.
// The receiver cannot stall: each result shows for exactly one cycle.
// Reset (rst_n, synchronous, low) clears the valid bits and restores limits 8 / 16.
module float_ulp_approx_equal_unit
  import fuaeq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  fuaeq_in_t   in_data,
  output logic        out_valid,
  output fuaeq_out_t  out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [62:0] cfg_wdata
);

  // ---------------- configuration ----------------
  logic [SGL_LIM_W-1:0] lim_sgl_r;
  logic [DBL_LIM_W-1:0] lim_dbl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_sgl_r <= ULP_LIMIT_SINGLE_RST;
      lim_dbl_r <= ULP_LIMIT_DOUBLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ULP_SINGLE: lim_sgl_r <= cfg_wdata[SGL_LIM_W-1:0];
        REG_ULP_DOUBLE: lim_dbl_r <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  // The pipeline advances every cycle; nothing holds it off.
  assign busy = 1'b0;
  logic acc;
  assign acc = start && !busy;

  // ---------------- stage 1: unpack and classify ----------------
  // Fold single precision into the 63-bit magnitude form.
  logic [62:0] ma, mb;
  logic        sa, sb, spec_a, spec_b, nan_a;
  always_comb begin
    if (in_data.command == CMD_DOUBLE) begin
      ma     = in_data.operand_a[62:0];
      mb     = in_data.operand_b[62:0];
      sa     = in_data.operand_a[63];
      sb     = in_data.operand_b[63];
      spec_a = &in_data.operand_a[62:52];
      spec_b = &in_data.operand_b[62:52];
      nan_a  = spec_a && (|in_data.operand_a[51:0]);
    end else begin
      ma     = {32'b0, in_data.operand_a[30:0]};
      mb     = {32'b0, in_data.operand_b[30:0]};
      sa     = in_data.operand_a[31];
      sb     = in_data.operand_b[31];
      spec_a = &in_data.operand_a[30:23];
      spec_b = &in_data.operand_b[30:23];
      nan_a  = spec_a && (|in_data.operand_a[22:0]);
    end
  end

  logic        v1_r, cmd1_r, sdiff1_r, spec1_r, eq1_r, ge1_r;
  logic [62:0] ma1_r, mb1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= acc;
  end

  always_ff @(posedge clk) begin
    cmd1_r   <= in_data.command;
    sdiff1_r <= sa ^ sb;
    spec1_r  <= spec_a || spec_b;
    // Equal as floating-point values: +0 and -0 match, NaN never does.
    eq1_r    <= ((ma == '0) && (mb == '0)) || ((ma == mb) && (sa == sb) && !nan_a);
    ge1_r    <= ma >= mb;
    ma1_r    <= ma;
    mb1_r    <= mb;
  end

  // ---------------- stage 2: order, distance, fixed point ----------------
  logic [62:0]       big, lo_mag, ulp_dist;
  logic [10:0]       exp_big, exp_small, eff_big, eff_small;
  logic [MANT_W-1:0] mant_big, mant_small;
  logic [FX_W-1:0]   fx_big, fx_small;
  logic              st_big, st_small;

  always_comb begin
    big    = ge1_r ? ma1_r : mb1_r;
    lo_mag = ge1_r ? mb1_r : ma1_r;
    if (cmd1_r == CMD_DOUBLE) begin
      exp_big    = big[62:52];
      exp_small  = lo_mag[62:52];
      mant_big   = {(exp_big != '0), big[51:0]};
      mant_small = {(exp_small != '0), lo_mag[51:0]};
    end else begin
      exp_big    = {3'b0, big[30:23]};
      exp_small  = {3'b0, lo_mag[30:23]};
      mant_big   = {29'b0, (exp_big != '0), big[22:0]};
      mant_small = {29'b0, (exp_small != '0), lo_mag[22:0]};
    end
    // Subnormals sit at the minimum normal exponent without the hidden bit.
    eff_big   = (exp_big == '0) ? 11'd1 : exp_big;
    eff_small = (exp_small == '0) ? 11'd1 : exp_small;
    if (eq1_r)                    ulp_dist = '0;
    else if (spec1_r || sdiff1_r) ulp_dist = (cmd1_r == CMD_DOUBLE) ? DIST_MAX_DBL
                                                                    : DIST_MAX_SGL;
    else                          ulp_dist = big - lo_mag;
  end

  fuaeq_to_fixed u_fx_big (
    .is_double (cmd1_r == CMD_DOUBLE),
    .exp_eff   (eff_big),
    .mant      (mant_big),
    .fx        (fx_big),
    .sticky    (st_big)
  );

  fuaeq_to_fixed u_fx_small (
    .is_double (cmd1_r == CMD_DOUBLE),
    .exp_eff   (eff_small),
    .mant      (mant_small),
    .fx        (fx_small),
    .sticky    (st_small)
  );

  logic            v2_r, cmd2_r, sdiff2_r, st2_r, below_one2_r, tiny2_r;
  logic [62:0]     dist2_r;
  logic [FX_W-1:0] fxb2_r, fxs2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    cmd2_r       <= cmd1_r;
    sdiff2_r     <= sdiff1_r;
    dist2_r      <= ulp_dist;
    fxb2_r       <= fx_big;
    fxs2_r       <= fx_small;
    // The larger value lies on the grid whenever it is not tiny, so its
    // sticky bit only shows up in the tiny case, which ignores it.
    st2_r        <= st_small || st_big;
    // Larger magnitude below 1.0: also rules out infinity and NaN.
    below_one2_r <= exp_big < ((cmd1_r == CMD_DOUBLE) ? ONE_EXP_DBL : ONE_EXP_SGL);
    tiny2_r      <= exp_big < ((cmd1_r == CMD_DOUBLE) ? TINY_EXP_DBL : TINY_EXP_SGL);
  end

  // ---------------- stage 3: exact difference, ULP limit ----------------
  logic           v3_r, cmd3_r, sdiff3_r, st3_r, below_one3_r, tiny3_r, ulp_ok3_r;
  logic [62:0]    dist3_r;
  logic [K_W-1:0] k3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    cmd3_r       <= cmd2_r;
    sdiff3_r     <= sdiff2_r;
    st3_r        <= st2_r;
    below_one3_r <= below_one2_r;
    tiny3_r      <= tiny2_r;
    dist3_r      <= dist2_r;
    // Opposite signs add magnitudes, equal signs subtract them.
    k3_r         <= sdiff2_r ? (K_W'(fxb2_r) + K_W'(fxs2_r))
                             : (K_W'(fxb2_r) - K_W'(fxs2_r));
    ulp_ok3_r    <= (cmd2_r == CMD_DOUBLE) ? (dist2_r <= lim_dbl_r)
                                           : (dist2_r <= 63'(lim_sgl_r));
  end

  // ---------------- stage 4: tolerance compare, output ----------------
  // Rounded difference is below tolerance iff the exact one is below the
  // midpoint; a tie rounds toward the even neighbor (below, for single).
  logic [K_W-1:0] mid;
  logic           tie_near, lt_mid, near_tol;

  always_comb begin
    mid      = (cmd3_r == CMD_DOUBLE) ? TOL_MID_DBL : TOL_MID_SGL;
    tie_near = (cmd3_r == CMD_SINGLE);
    if (!st3_r)         lt_mid = (k3_r < mid) || (tie_near && (k3_r == mid));
    else if (!sdiff3_r) lt_mid = k3_r <= mid;   // exact value just under k
    else                lt_mid = k3_r < mid;    // exact value just over k
    near_tol = below_one3_r && (tiny3_r || lt_mid);
  end

  logic       out_valid_r;
  fuaeq_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    out_data_r.equal        <= near_tol || ulp_ok3_r;
    out_data_r.ulp_distance <= dist3_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* src/fuaeq_to_fixed.sv */
// Converts an unpacked magnitude below 1.0 to the fixed-point tolerance grid.
// Depends on fuaeq_pkg.
module fuaeq_to_fixed
  import fuaeq_pkg::*;
(
  input  logic              is_double,
  input  logic [10:0]       exp_eff,
  input  logic [MANT_W-1:0] mant,
  output logic [FX_W-1:0]   fx,
  output logic              sticky
);

  logic signed [12:0]        sh;
  logic        [12:0]        nr;
  logic [2*MANT_W-1:0]       wide;

  always_comb begin
    sh     = $signed({2'b00, exp_eff}) -
             $signed(is_double ? GRID_OFS_DBL : GRID_OFS_SGL);
    nr     = 13'(-sh);
    wide   = '0;
    fx     = '0;
    sticky = 1'b0;
    if (sh >= 0) begin
      fx = FX_W'(mant) << sh[6:0];
    end else if (nr >= 13'(MANT_W)) begin
      sticky = |mant;
    end else begin
      wide   = {mant, {MANT_W{1'b0}}} >> nr[5:0];
      fx     = FX_W'(wide[2*MANT_W-1:MANT_W]);
      sticky = |wide[MANT_W-1:0];
    end
  end

endmodule

/* src/fuaeq_checker.sv */
// Port-level checker for the float ULP approximate-equality unit, with its bind.
// Depends on fuaeq_pkg; attaches to float_ulp_approx_equal_unit.
module fuaeq_checker
  import fuaeq_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input fuaeq_in_t  in_data,
  input logic       out_valid,
  input fuaeq_out_t out_data
);

  // Every accepted word yields a result strobe.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_valid)
    else $error("result strobe missing after accepted word");

  // No strobe without a matching earlier accepted word.
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 4))
    else $error("result strobe without accepted word");

  // Distance zero always passes the ULP limit.
  a_zero_equal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.ulp_distance == '0)) |-> out_data.equal)
    else $error("zero distance reported unequal");

  // Single-precision distances fit in 31 bits.
  a_sgl_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ($past(in_data.command, 4) == CMD_SINGLE))
      |-> (out_data.ulp_distance[62:31] == '0))
    else $error("single distance out of range");

endmodule

bind float_ulp_approx_equal_unit fuaeq_checker u_fuaeq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

/* test/float_ulp_approx_equal_unit_tb.sv */
// Testbench for float_ulp_approx_equal_unit: directed table plus random words,
// checked against an in-bench predictor of the tolerance and ULP tests.
// Depends on fuaeq_pkg and the RTL of the unit only.
module float_ulp_approx_equal_unit_tb
  import fuaeq_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 12;
  localparam int RAND_WORDS     = 400;
  localparam int NUM_PHASES     = 5;

  // Single-precision tolerance 1e-8f and its float predecessor.
  localparam logic [31:0] SGL_TOL_BITS  = 32'h322B_CC77;
  localparam logic [31:0] SGL_TOL_PRED  = 32'h322B_CC76;
  localparam logic [63:0] DBL_TOL_BITS  = 64'h3C9C_D2B2_97D8_89BC;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  fuaeq_in_t   in_data;
  logic        out_valid;
  fuaeq_out_t  out_data;
  logic        cfg_we;
  logic        cfg_index;
  logic [62:0] cfg_wdata;

  float_ulp_approx_equal_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Limits as the predictor sees them.
  logic [30:0] limit_sgl;
  logic [62:0] limit_dbl;

  fuaeq_out_t  pending_results[$];
  int          fail_count;
  int          quiet_cycles;
  bit          idling_on;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Widen a single bit pattern into an exact real (subnormals included).
  function automatic real sgl_to_real(logic [31:0] x);
    logic [7:0]  e;
    logic [22:0] m;
    real         r;
    e = x[30:23];
    m = x[22:0];
    if (e == 8'hFF) return $bitstoreal({x[31], 11'h7FF, m, 29'b0});
    if (e == 8'h00) begin
      r = real'(m) * (2.0 ** (-149));
      return x[31] ? -r : r;
    end
    return $bitstoreal({x[31], 11'(e) + 11'd896, m, 29'b0});
  endfunction

  function automatic fuaeq_out_t predict_compare(fuaeq_in_t w);
    fuaeq_out_t  res;
    real         ra, rb, diff, mid;
    logic [63:0] ma, mb;
    logic [31:0] sa, sb;
    bit          near;
    if (w.command == CMD_SINGLE) begin
      sa = w.operand_a[31:0];
      sb = w.operand_b[31:0];
      ra = sgl_to_real(sa);
      rb = sgl_to_real(sb);
      // Difference is exact in double whenever it lies near the tolerance.
      diff = ra - rb;
      if (diff < 0.0) diff = -diff;
      // Round-to-single lands below 1e-8f up to the midpoint; the tie goes
      // to the even predecessor.
      mid = (sgl_to_real(SGL_TOL_BITS) + sgl_to_real(SGL_TOL_PRED)) / 2.0;
      ma = {33'b0, sa[30:0]};
      mb = {33'b0, sb[30:0]};
      if (ra == rb) res.ulp_distance = '0;
      else if (sa[30:23] == 8'hFF || sb[30:23] == 8'hFF) res.ulp_distance = DIST_MAX_SGL;
      else if (sa[31] != sb[31]) res.ulp_distance = DIST_MAX_SGL;
      else res.ulp_distance = 63'(ma >= mb ? ma - mb : mb - ma);
      near = (diff <= mid) || (res.ulp_distance <= {32'b0, limit_sgl});
    end else begin
      ra = $bitstoreal(w.operand_a);
      rb = $bitstoreal(w.operand_b);
      diff = ra - rb;
      if (diff < 0.0) diff = -diff;
      ma = {1'b0, w.operand_a[62:0]};
      mb = {1'b0, w.operand_b[62:0]};
      if (ra == rb) res.ulp_distance = '0;
      else if (w.operand_a[62:52] == 11'h7FF || w.operand_b[62:52] == 11'h7FF)
        res.ulp_distance = DIST_MAX_DBL;
      else if (w.operand_a[63] != w.operand_b[63]) res.ulp_distance = DIST_MAX_DBL;
      else res.ulp_distance = 63'(ma >= mb ? ma - mb : mb - ma);
      near = (diff < $bitstoreal(DBL_TOL_BITS)) || (res.ulp_distance <= limit_dbl);
    end
    res.equal = near;
    return res;
  endfunction

  // Result side: the receiver cannot stall, so check every strobe.
  always @(posedge clk) begin
    fuaeq_out_t exp_res;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: equal=%0b ulp_distance=%0h",
               out_data.equal, out_data.ulp_distance);
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_data.equal !== exp_res.equal) begin
          $error("equal: expected %0b, actual %0b", exp_res.equal, out_data.equal);
          fail_count++;
        end
        if (out_data.ulp_distance !== exp_res.ulp_distance) begin
          $error("ulp_distance: expected %0h, actual %0h",
                 exp_res.ulp_distance, out_data.ulp_distance);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: count cycles in which no word moves on either side and no limit is written.
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy) || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** float_ulp_approx_equal_unit: FAILED **");
      $finish;
    end
  end

  // Hold start high until the word is taken; push expectation on acceptance.
  task automatic send_word(fuaeq_in_t w, bit typed, fuaeq_out_t typed_res);
    @(negedge clk);
    start   <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy);
    pending_results.push_back(typed ? typed_res : predict_compare(w));
  endtask

  task automatic idle_burst();
    int n;
    if (!idling_on || $urandom_range(3) != 0) return;
    n = $urandom_range(11, 1);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write one limit register; only called with the pipeline drained.
  task automatic write_limit(logic idx, logic [62:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_ULP_SINGLE) limit_sgl = value[30:0];
    else limit_dbl = value;
  endtask

  // Random single pattern, weighted toward interesting corners.
  function automatic logic [31:0] rand_sgl();
    case ($urandom_range(7))
      0: return 32'h0000_0000 | ($urandom_range(1) << 31);
      1: return {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(1) ? $urandom : 0)};
      2: return {1'($urandom_range(1)), 8'h00, 23'($urandom)};
      3: return {1'($urandom_range(1)), 8'($urandom_range(110, 90)), 23'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] rand_dbl();
    case ($urandom_range(7))
      0: return {1'($urandom_range(1)), 63'b0};
      1: return {1'($urandom_range(1)), 11'h7FF,
                 52'($urandom_range(1) ? {$urandom, $urandom} : 0)};
      2: return {1'($urandom_range(1)), 11'h000, 52'({$urandom, $urandom})};
      3: return {1'($urandom_range(1)), 11'($urandom_range(990, 950)),
                 52'({$urandom, $urandom})};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Half of the pairs are near pairs, so both tolerance and ULP tests are exercised.
  function automatic fuaeq_in_t rand_word(logic [62:0] span);
    fuaeq_in_t   w;
    logic [63:0] delta;
    w.command = 1'($urandom_range(1));
    delta = 64'($urandom_range(32'(span > 63'd64 ? 64 : span) + 4));
    if (w.command == CMD_SINGLE) begin
      w.operand_a = {$urandom, rand_sgl()};
      w.operand_b = {$urandom, rand_sgl()};
      case ($urandom_range(3))
        0, 1: w.operand_b[31:0] = $urandom_range(1) ? w.operand_a[31:0] + 32'(delta)
                                                    : w.operand_a[31:0] - 32'(delta);
        2: w.operand_b[31:0] = w.operand_a[31:0] ^ 32'h8000_0000;
        default: ;
      endcase
    end else begin
      w.operand_a = rand_dbl();
      w.operand_b = rand_dbl();
      case ($urandom_range(3))
        0, 1: w.operand_b = $urandom_range(1) ? w.operand_a + delta : w.operand_a - delta;
        2: w.operand_b = w.operand_a ^ 64'h8000_0000_0000_0000;
        default: ;
      endcase
    end
    return w;
  endfunction

  typedef struct {
    logic        command;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
    bit          typed;
    logic        equal;
    logic [62:0] ulp_distance;
  } stim_row_t;

  // Directed table; typed rows carry the result read off by hand.
  stim_row_t directed_rows[] = '{
    '{CMD_SINGLE, 64'h0, 64'h8000_0000, 1, 1'b1, 63'd0},
    '{CMD_SINGLE, 64'h7FC0_0000, 64'h7FC0_0000, 1, 1'b0, DIST_MAX_SGL},
    '{CMD_SINGLE, 64'h7F80_0000, 64'h7F80_0000, 1, 1'b1, 63'd0},
    '{CMD_SINGLE, 64'h3F80_0000, 64'hBF80_0000, 1, 1'b0, DIST_MAX_SGL},
    '{CMD_SINGLE, 64'h3F80_0000, 64'h3F80_0008, 1, 1'b1, 63'd8},
    '{CMD_SINGLE, 64'h3F80_0000, 64'h3F80_0009, 1, 1'b0, 63'd9},
    '{CMD_SINGLE, 64'hDEAD_BEEF_3F80_0000, 64'h1234_5678_3F80_0000, 1, 1'b1, 63'd0},
    '{CMD_SINGLE, 64'h0000_0001, 64'h8000_0001, 1, 1'b1, DIST_MAX_SGL},
    '{CMD_SINGLE, 64'h7F7F_FFFF, 64'h0, 1, 1'b0, 63'h7F7F_FFFF},
    '{CMD_SINGLE, 64'(SGL_TOL_BITS), 64'h0, 0, 1'b0, 63'd0},
    '{CMD_SINGLE, 64'(SGL_TOL_PRED), 64'h0, 0, 1'b0, 63'd0},
    '{CMD_SINGLE, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_7F80_0000, 1, 1'b0, DIST_MAX_SGL},
    '{CMD_DOUBLE, 64'h0, 64'h8000_0000_0000_0000, 1, 1'b1, 63'd0},
    '{CMD_DOUBLE, 64'h7FF8_0000_0000_0000, 64'h3FF0_0000_0000_0000, 1, 1'b0, DIST_MAX_DBL},
    '{CMD_DOUBLE, 64'hFFF0_0000_0000_0000, 64'hFFF0_0000_0000_0000, 1, 1'b1, 63'd0},
    '{CMD_DOUBLE, 64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0010, 1, 1'b1, 63'd16},
    '{CMD_DOUBLE, 64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0011, 1, 1'b0, 63'd17},
    '{CMD_DOUBLE, 64'h1, 64'h8000_0000_0000_0001, 1, 1'b1, DIST_MAX_DBL},
    '{CMD_DOUBLE, 64'h7FEF_FFFF_FFFF_FFFF, 64'h0, 1, 1'b0, 63'h7FEF_FFFF_FFFF_FFFF},
    '{CMD_DOUBLE, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1, 1'b0, DIST_MAX_DBL},
    '{CMD_DOUBLE, DBL_TOL_BITS, 64'h0, 0, 1'b0, 63'd0},
    '{CMD_DOUBLE, DBL_TOL_BITS - 64'd1, 64'h0, 0, 1'b0, 63'd0},
    '{CMD_DOUBLE, DBL_TOL_BITS, 64'h8000_0000_0000_0000, 0, 1'b0, 63'd0}
  };

  initial begin
    fuaeq_in_t   w;
    fuaeq_out_t  typed_res;
    logic [62:0] lim_s, lim_d;
    start        = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_index    = REG_ULP_SINGLE;
    cfg_wdata    = '0;
    fail_count   = 0;
    quiet_cycles = 0;
    idling_on    = 1'b1;
    limit_sgl    = ULP_LIMIT_SINGLE_RST;
    limit_dbl    = ULP_LIMIT_DOUBLE_RST;
    rst_n        = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part runs on the reset limits, back to back.
    foreach (directed_rows[i]) begin
      w.command         = directed_rows[i].command;
      w.operand_a       = directed_rows[i].operand_a;
      w.operand_b       = directed_rows[i].operand_b;
      typed_res.equal        = directed_rows[i].equal;
      typed_res.ulp_distance = directed_rows[i].ulp_distance;
      send_word(w, directed_rows[i].typed, typed_res);
    end

    // Random phases, each on its own pair of limits; extremes first.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      case (p)
        0: begin lim_s = '0;                    lim_d = '0; end
        1: begin lim_s = {32'h7FFF_FFFF, 31'h7FFF_FFFF}; lim_d = '1; end
        2: begin lim_s = 63'd3;                 lim_d = 63'd40; end
        default: begin
          lim_s = 63'({$urandom, $urandom});
          lim_d = 63'($urandom_range(1) ? {$urandom, $urandom} : $urandom_range(64));
        end
      endcase
      write_limit(REG_ULP_SINGLE, lim_s);
      write_limit(REG_ULP_DOUBLE, lim_d);
      // Last phase runs flat out with no gaps.
      idling_on = (p != NUM_PHASES - 1);
      for (int k = 0; k < RAND_WORDS / NUM_PHASES; k++) begin
        idle_burst();
        send_word(rand_word(p == 2 ? lim_d : 63'd20), 1'b0, typed_res);
      end
    end

    drain_results();
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("** float_ulp_approx_equal_unit: PASSED **");
    end else begin
      $display("** float_ulp_approx_equal_unit: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
src/fuaeq_pkg.sv
src/fuaeq_to_fixed.sv
src/float_ulp_approx_equal_unit.sv
src/fuaeq_checker.sv
test/float_ulp_approx_equal_unit_tb.sv
